@@ design/bse_pkg.sv @@
// bse_pkg: shared types and constants for the battery charge estimator.
// Holds the open-circuit-voltage table, field widths and the sequencer state type.
// No dependencies.
`default_nettype none
package bse_pkg;

   localparam int MV_W    = 16;
   localparam int PCT_W   = 7;
   localparam int SPAN_W  = 9;
   localparam int NUM_W   = 12;
   localparam int QUOT_W  = 4;
   localparam int POINTS  = 11;
   localparam int SEGS    = POINTS - 1;
   localparam int SEG_W   = 4;

   localparam logic [MV_W-1:0] OCV_TABLE [POINTS] = '{
      16'd4200, 16'd4060, 16'd3980, 16'd3920, 16'd3870, 16'd3820,
      16'd3790, 16'd3770, 16'd3740, 16'd3680, 16'd3300
   };

   localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
   localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

   // percent at the bottom of segment k: 90 - 10*k
   function automatic logic [PCT_W-1:0] seg_base(input logic [SEG_W-1:0] k);
      logic [PCT_W-1:0] tens;
      tens = {3'b000, k};
      return 7'd90 - ((tens << 3) + (tens << 1));
   endfunction

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_FILT = 5'b00010,
      ST_SEG  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

endpackage
`default_nettype wire

@@ design/bse_div.sv @@
// bse_div: iterative restoring divider, one quotient bit per cycle.
// One shared subtract-compare unit; depends on bse_pkg for widths.
`default_nettype none
module bse_div
   import bse_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [NUM_W-1:0]  numer,
   input  wire logic [SPAN_W-1:0] denom,
   output logic                   done,
   output logic [QUOT_W-1:0]      quot
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [SPAN_W-1:0] den_ff, den_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [NUM_W:0]    trial;
   logic [NUM_W-1:0]  den_sh;

   assign den_sh = {{(NUM_W-SPAN_W){1'b0}}, den_ff} << cnt_ff;
   assign trial  = {1'b0, rem_ff} - {1'b0, den_sh};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 2'd3;
         rem_in  = numer;
         den_in  = denom;
         quot_in = '0;
      end else if (busy_ff) begin
         if (!trial[NUM_W]) begin
            rem_in = trial[NUM_W-1:0];
         end
         quot_in = {quot_ff[QUOT_W-2:0], ~trial[NUM_W]};
         cnt_in  = cnt_ff - 2'd1;
         if (cnt_ff == 2'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a run");
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < {{(NUM_W-SPAN_W){1'b0}}, den_ff})
      else $error("divider remainder not reduced");
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

endmodule
`default_nettype wire

@@ design/battery_soc_estimator.sv @@
// battery_soc_estimator: filtered cell voltage to held state of charge.
// Sequencer over a filter step, segment lookup and bse_div; uses bse_pkg.
//
//  channel  direction  ports                                handshake
//  req      in         req_cell_mv, req_is_charging         req_valid / req_stall
//  rsp      out        rsp_charge_percent                   rsp_valid / rsp_stall
//
// Each sample steps from the input transfer through the filter and segment states
// to the done state, where the result is registered; inside the table range it also
// passes the divide state and the divider's quotient loop. The next input transfer
// waits for all of this, plus any wait while the previous result is stalled.
// Reset clears the filter, held charge and primed flag; first sample primes.
// req_stall is high from acceptance until the result is registered.
`default_nettype none
module battery_soc_estimator
   import bse_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [MV_W-1:0]  req_cell_mv,
   input  wire logic             req_is_charging,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [PCT_W-1:0]      rsp_charge_percent
);

   state_type         state_ff, state_in;
   logic [MV_W-1:0]   avg_ff, avg_in;
   logic [PCT_W-1:0]  held_ff, held_in;
   logic              primed_ff, primed_in;
   logic [MV_W-1:0]   mv_ff, mv_in;
   logic              chg_ff, chg_in;
   logic [PCT_W-1:0]  est_ff, est_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PCT_W-1:0]  rsp_pct_ff, rsp_pct_in;

   logic [MV_W+3:0]   filt_sum;
   logic [SEG_W-1:0]  seg;
   logic [SPAN_W-1:0] span;
   logic [SPAN_W-1:0] diff;
   logic [NUM_W-1:0]  numer;
   logic [NUM_W-1:0]  diff_w;
   logic              div_start;
   logic              div_done;
   logic [QUOT_W-1:0] div_quot;
   logic [PCT_W-1:0]  final_pct;

   assign filt_sum = ({4'b0000, avg_ff} << 3) - {4'b0000, avg_ff} + {4'b0000, mv_ff};

   always_comb begin
      seg = '0;
      for (int k = SEGS - 1; k >= 0; k--) begin
         if (avg_ff <= OCV_TABLE[k] && avg_ff > OCV_TABLE[k+1]) begin
            seg = SEG_W'(k);
         end
      end
   end

   always_comb begin
      span = SPAN_W'(OCV_TABLE[seg] - OCV_TABLE[seg + SEG_W'(1)]);
      diff = SPAN_W'(avg_ff - OCV_TABLE[seg + SEG_W'(1)]);
   end

   assign diff_w = {{(NUM_W-SPAN_W){1'b0}}, diff};
   assign numer  = (diff_w << 3) + (diff_w << 1);

   bse_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (numer),
      .denom (span),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      if (!primed_ff) begin
         final_pct = est_ff;
      end else if (chg_ff) begin
         final_pct = (est_ff > held_ff) ? est_ff : held_ff;
      end else begin
         final_pct = (est_ff < held_ff) ? est_ff : held_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      avg_in       = avg_ff;
      held_in      = held_ff;
      primed_in    = primed_ff;
      mv_in        = mv_ff;
      chg_in       = chg_ff;
      est_in       = est_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pct_in   = rsp_pct_ff;
      div_start    = 1'b0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mv_in    = req_cell_mv;
               chg_in   = req_is_charging;
               state_in = ST_FILT;
            end
         end
         ST_FILT: begin
            avg_in   = primed_ff ? filt_sum[MV_W+2:3] : mv_ff;
            state_in = ST_SEG;
         end
         ST_SEG: begin
            if (avg_ff >= OCV_TABLE[0]) begin
               est_in   = PCT_FULL;
               state_in = ST_DONE;
            end else if (avg_ff <= OCV_TABLE[SEGS]) begin
               est_in   = PCT_EMPTY;
               state_in = ST_DONE;
            end else begin
               est_in    = seg_base(seg);
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               est_in   = est_ff + {3'b000, div_quot};
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               held_in      = final_pct;
               primed_in    = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_pct_in   = final_pct;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         avg_ff       <= '0;
         held_ff      <= '0;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         avg_ff       <= avg_in;
         held_ff      <= held_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mv_ff      <= mv_in;
      chg_ff     <= chg_in;
      est_ff     <= est_in;
      rsp_pct_ff <= rsp_pct_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_charge_percent = rsp_pct_ff;

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider result outside divide state");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside done state");
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_pct_ff <= PCT_FULL && held_ff <= PCT_FULL)
      else $error("charge out of range");
   a_primed_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> primed_ff)
      else $error("result without primed filter");

endmodule
`default_nettype wire
